// ----- hdl/deq_pkg.sv -----
// Shared constants for the double-ended queue: command and status codes,
// field widths and parameter defaults.
// No dependencies.
package deq_pkg;

    localparam int DEQ_DEPTH      = 16;
    localparam int DEQ_DATA_WIDTH = 32;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

// ----- hdl/double_ended_queue_core.sv -----
// Push, clear, unused commands and reads of an empty queue put their result beat in the
// output register in the cycle after acceptance; a pop or peek that reads the store
// passes through the read state and the store's registered read port first.
// Throughput: one command per cycle while results are taken; store reads block the next one.
// Reset (synchronous, active low) clears both indices, the count and the control state
// and holds the input off; the entry store is never cleared. Depends on deq_pkg.
module double_ended_queue_core #(
    parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // slave side: one command beat
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    input  logic [deq_pkg::VALUE_W-1:0]              i_s_tdata,  // [31:0] value
    input  logic [deq_pkg::CMD_W-1:0]                i_s_tuser,  // [2:0] command
    // master side: one result beat per command
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    output logic [deq_pkg::VALUE_W-1:0]              o_m_tdata,  // [31:0] data
    // from bit 0: status (2), is_empty (1), count (CNT_W)
    output logic [deq_pkg::STAT_W+CNT_W:0]           o_m_tuser
);
    import deq_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    // ring store
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // control state
    logic             r_state;
    logic [AW-1:0]    r_front, n_front;
    logic [AW-1:0]    r_back,  n_back;
    logic [CNT_W-1:0] r_count, n_count;

    // output register
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_data;
    logic [STAT_W-1:0]  r_out_status;
    logic [CNT_W-1:0]   r_out_count;

    logic                     w_accept;
    logic [CMD_W-1:0]         w_cmd;
    logic                     w_empty, w_full;
    logic [AW-1:0]            w_front_up, w_front_dn, w_back_up, w_back_dn;
    logic                     w_we, w_re;
    logic [AW-1:0]            w_addr;
    logic [STAT_W-1:0]        w_status;
    logic [VALUE_W-1:0]       w_data;
    logic signed [EXT_W-1:0]  w_val_ext;
    logic signed [EXT_W-1:0]  w_rd_ext;

    assign w_cmd   = i_s_tuser;
    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(DEPTH));

    // Take a new command only out of reset, with no read in flight and the output
    // free next cycle.
    assign o_s_tready = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // wrap the indices around a ring of any depth
    assign w_front_up = (r_front == LAST_SLOT) ? '0 : r_front + 1'b1;
    assign w_front_dn = (r_front == '0) ? LAST_SLOT : r_front - 1'b1;
    assign w_back_up  = (r_back == LAST_SLOT) ? '0 : r_back + 1'b1;
    assign w_back_dn  = (r_back == '0) ? LAST_SLOT : r_back - 1'b1;

    // The pushed word keeps its low DATA_WIDTH bits; a read sign-extends them back.
    assign w_val_ext = EXT_W'($signed(i_s_tdata));
    assign w_rd_ext  = EXT_W'($signed(r_rd_data));

    // Decode the command: next indices and count, store access, immediate result.
    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_addr   = r_front;
        w_status = STAT_OK;
        w_data   = '0;
        case (w_cmd)
            CMD_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = STAT_FULL;
                end else begin
                    w_we    = w_accept;
                    w_addr  = w_front_dn;
                    n_front = w_front_dn;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (w_full) begin
                    w_status = STAT_FULL;
                end else begin
                    w_we    = w_accept;
                    w_addr  = r_back;
                    n_back  = w_back_up;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (w_empty) begin
                    w_status = STAT_EMPTY;
                    w_data   = '1;
                end else begin
                    w_re    = w_accept;
                    w_addr  = r_front;
                    n_front = w_front_up;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (w_empty) begin
                    w_status = STAT_EMPTY;
                    w_data   = '1;
                end else begin
                    w_re    = w_accept;
                    w_addr  = w_back_dn;
                    n_back  = w_back_dn;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_PEEK_FRONT: begin
                if (w_empty) begin
                    w_status = STAT_EMPTY;
                    w_data   = '1;
                end else begin
                    w_re   = w_accept;
                    w_addr = r_front;
                end
            end
            CMD_PEEK_BACK: begin
                if (w_empty) begin
                    w_status = STAT_EMPTY;
                    w_data   = '1;
                end else begin
                    w_re   = w_accept;
                    w_addr = w_back_dn;
                end
            end
            CMD_CLEAR: begin
                n_front = '0;
                n_back  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Store: one write or one registered read per accepted command.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_val_ext[DATA_WIDTH-1:0];
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    // Control: indices, count, read sequencing and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_count <= n_count;
                if (w_re) begin
                    r_state <= S_READ;
                end
            end
            if (r_state == S_READ) begin
                // store data has arrived: release the result beat
                r_state <= S_IDLE;
            end
            // raise valid for a finished result, drop it once the beat is taken
            if ((w_accept && !w_re) || (r_state == S_READ)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: status and count at acceptance, read data once the store read returns.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_status <= w_status;
            r_out_count  <= n_count;
            r_out_data   <= w_data;
        end
        if (r_state == S_READ) begin
            r_out_data <= w_rd_ext[VALUE_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = {r_out_count, (r_out_count == '0), r_out_status};

endmodule

// ----- hdl/deq_checker.sv -----
// Port-level checks for the double-ended queue, bound to its top level.
// Depends on deq_pkg and double_ended_queue_core.
module deq_checker #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [deq_pkg::STAT_W+CNT_W:0]  o_m_tuser
);
    import deq_pkg::*;

    logic [STAT_W-1:0] w_status;
    logic              w_is_empty;
    logic [CNT_W-1:0]  w_count;

    assign w_status   = o_m_tuser[STAT_W-1:0];
    assign w_is_empty = o_m_tuser[STAT_W];
    assign w_count    = o_m_tuser[STAT_W+CNT_W:STAT_W+1];

    // a stalled result must block the next command
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("command taken while result beat is stalled");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped before it was taken");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_count <= CNT_W'(DEPTH)) && (w_is_empty == (w_count == '0)))
        else $error("count out of range or empty flag inconsistent");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (w_status == STAT_FULL) |-> (w_count == CNT_W'(DEPTH)))
        else $error("full status reported below capacity");

endmodule

bind double_ended_queue_core deq_checker #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
) u_deq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tuser  (o_m_tuser)
);

// ----- test/double_ended_queue_core_test.sv -----
// Self-checking testbench for double_ended_queue_core: streams commands in, checks every
// result beat against a behavioural deque held in a small scoreboard class.
// Depends on deq_pkg and double_ended_queue_core.
`timescale 1ns / 100ps

module double_ended_queue_core_test;

    import deq_pkg::*;

    localparam int IDX_W   = $clog2(DEQ_DEPTH);
    localparam int CNT_W   = $clog2(DEQ_DEPTH + 1);
    localparam int TUSER_W = STAT_W + CNT_W + 1;

    // the one command code the package leaves unnamed: the block must treat it as a no-op
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    localparam int RANDOM_BEATS = 420;
    localparam int QUIET_BEATS  = 60;   // tail of the run with no idling on either side
    localparam int SEGMENT_LEN  = 24;   // beats per fill / drain / mixed segment
    localparam int HOLD_AFTER   = 150;  // results seen before the long receiver hold
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} t_segment;

    typedef struct packed {
        logic [VALUE_W-1:0] data;
        logic [STAT_W-1:0]  status;
        logic               is_empty;
        logic [CNT_W-1:0]   count;
    } t_deq_result;

    // Behavioural deque plus the queue of results it has promised.
    class deq_scoreboard;
        logic [DEQ_DATA_WIDTH-1:0] slots [DEQ_DEPTH];
        logic [IDX_W-1:0]          head;
        logic [IDX_W-1:0]          tail;
        logic [CNT_W-1:0]          held;
        t_deq_result               pending_results [$];
        int                        errors;
        int                        checked;

        function new();
            head    = '0;
            tail    = '0;
            held    = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s", $time, msg);
        endfunction

        function t_deq_result apply_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val);
            t_deq_result      r;
            logic [IDX_W-1:0] back_slot;
            r.data    = '0;
            r.status  = STAT_OK;
            back_slot = tail - 1'b1;
            case (cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (held == DEQ_DEPTH) begin
                        r.status = STAT_FULL;
                    end else if (cmd == CMD_PUSH_FRONT) begin
                        head        = head - 1'b1;
                        slots[head] = val;
                        held++;
                    end else begin
                        slots[tail] = val;
                        tail        = tail + 1'b1;
                        held++;
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
                    if (held == 0) begin
                        r.data   = '1;
                        r.status = STAT_EMPTY;
                    end else if (cmd == CMD_POP_FRONT) begin
                        r.data = slots[head];
                        head   = head + 1'b1;
                        held--;
                    end else if (cmd == CMD_POP_BACK) begin
                        tail   = back_slot;
                        r.data = slots[tail];
                        held--;
                    end else if (cmd == CMD_PEEK_FRONT) begin
                        r.data = slots[head];
                    end else begin
                        r.data = slots[back_slot];
                    end
                end
                CMD_CLEAR: begin
                    head = '0;
                    tail = '0;
                    held = '0;
                end
                default: ;
            endcase
            r.is_empty = (held == 0);
            r.count    = held;
            return r;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val);
            t_deq_result r;
            r = apply_command(cmd, val);
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void check_result(logic [VALUE_W-1:0] data, logic [TUSER_W-1:0] user);
            t_deq_result seen;
            t_deq_result want;
            seen.data     = data;
            seen.status   = user[STAT_W-1:0];
            seen.is_empty = user[STAT_W];
            seen.count    = user[STAT_W+1 +: CNT_W];
            checked++;
            if (pending_results.size() == 0) begin
                flag_error($sformatf("unexpected result beat: data=%h status=%0d empty=%0d count=%0d",
                                     seen.data, seen.status, seen.is_empty, seen.count));
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            if (seen.data !== want.data || seen.status !== want.status ||
                seen.is_empty !== want.is_empty || seen.count !== want.count)
                flag_error($sformatf({"result %0d mismatch: expected data=%h status=%0d empty=%0d",
                                      " count=%0d, got data=%h status=%0d empty=%0d count=%0d"},
                                     checked, want.data, want.status, want.is_empty, want.count,
                                     seen.data, seen.status, seen.is_empty, seen.count));
        endfunction
    endclass

    // every input known from time zero
    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [VALUE_W-1:0] i_s_tdata  = '0;   // [31:0] value
    logic [CMD_W-1:0]   i_s_tuser  = '0;   // [2:0] command
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [VALUE_W-1:0] o_m_tdata;         // [31:0] data
    logic [TUSER_W-1:0] o_m_tuser;         // [1:0] status, [2] is_empty, [7:3] count

    bit             quiet_phase = 1'b0;
    int             cycle_count = 0;
    deq_scoreboard  sb = new();

    double_ended_queue_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run; the limit is far above the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Check each result beat at the rising edge it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tuser);
    end

    // Result sink: random stall bursts, one long hold to back the block up, none at the end.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!hold_done && sb.checked >= HOLD_AFTER) begin
                // hold off long enough for the output register and input to fill and stall
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                i_m_tready = 1'b0;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    // Offer one command beat and hold it until taken. Called and returns just after a
    // falling edge; valid stays high straight into the next beat unless a gap is drawn.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
        int gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            gap        = $urandom_range(1, 10);
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = cmd;
        i_s_tdata  = val;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_command(cmd, val);
        @(negedge i_clk);
    endtask

    // Mostly full-range random words, with the extremes mixed in now and then.
    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Draw a command shaped by the current segment so the queue both fills and drains.
    function automatic logic [CMD_W-1:0] pick_command(t_segment seg);
        int roll;
        int push_pct;
        roll = $urandom_range(0, 99);
        if (roll < 2) return CMD_CLEAR;
        if (roll < 4) return CMD_UNUSED;
        case (seg)
            SEG_FILL:  push_pct = 75;
            SEG_DRAIN: push_pct = 25;
            default:   push_pct = 50;
        endcase
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        case ($urandom_range(0, 5))
            0, 1:    return CMD_POP_FRONT;
            2, 3:    return CMD_POP_BACK;
            4:       return CMD_PEEK_FRONT;
            default: return CMD_PEEK_BACK;
        endcase
    endfunction

    initial begin : stimulus
        t_segment seg;
        seg = SEG_MIXED;

        // hold reset, then release it at a falling edge
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reads of an empty queue at both ends
        send_beat(CMD_POP_FRONT, $urandom());
        send_beat(CMD_PEEK_BACK, $urandom());
        // extremes in at both ends, read back without and with removal
        send_beat(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        send_beat(CMD_PUSH_BACK, 32'h8000_0000);
        send_beat(CMD_PEEK_FRONT, $urandom());
        send_beat(CMD_PEEK_BACK, $urandom());
        send_beat(CMD_POP_BACK, $urandom());
        send_beat(CMD_POP_FRONT, $urandom());
        // leave one word behind, then clear it away and read the other ends empty
        send_beat(CMD_PUSH_BACK, 32'hFFFF_FFFF);
        send_beat(CMD_CLEAR, $urandom());
        send_beat(CMD_POP_BACK, $urandom());
        send_beat(CMD_PEEK_FRONT, $urandom());
        send_beat(CMD_UNUSED, $urandom());
        // fill from both ends so the indices wrap, then push into a full queue
        for (int i = 0; i < DEQ_DEPTH; i++)
            send_beat(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_word());
        send_beat(CMD_PUSH_FRONT, pick_word());
        send_beat(CMD_PUSH_BACK, pick_word());

        // random segments: fill, drain or mixed, re-drawn every SEGMENT_LEN beats
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % SEGMENT_LEN == 0)
                seg = t_segment'($urandom_range(0, 2));
            if (n == RANDOM_BEATS - QUIET_BEATS)
                quiet_phase = 1'b1;
            send_beat(pick_command(seg), pick_word());
        end
        i_s_tvalid = 1'b0;

        // wait for every outstanding result, then watch for strays a little longer
        while (sb.pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/deq_pkg.sv
hdl/double_ended_queue_core.sv
hdl/deq_checker.sv
test/double_ended_queue_core_test.sv
